// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules of the alu instruction encoder
// depends on nothing; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define X86E_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define X86E_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/x86e_pkg.sv =====
// types, codes and helper functions for the alu instruction encoder
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package x86e_pkg;

    localparam int MAX_BYTES = 11;
    localparam int IDX_W     = 4;

    localparam logic [2:0] KIND_REG_REG = 3'd0;
    localparam logic [2:0] KIND_REG_MEM = 3'd1;
    localparam logic [2:0] KIND_MEM_REG = 3'd2;
    localparam logic [2:0] KIND_REG_IMM = 3'd3;
    localparam logic [2:0] KIND_MEM_IMM = 3'd4;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;
    localparam logic [1:0] SIZE_RSVD  = 2'd3;

    localparam logic [2:0] REG_ACC = 3'd0;
    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP32 = 3'd5;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [7:0] PFX_OPSIZE    = 8'h66;
    localparam logic [7:0] OPC_GRP1_B    = 8'h80;
    localparam logic [7:0] OPC_GRP1_V    = 8'h81;
    localparam logic [7:0] OPC_GRP1_IMM8 = 8'h83;
    localparam logic [7:0] SIB_ESP_BASE  = 8'h24;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          len;
        logic                      illegal;
    } t_desc;

    function automatic logic fits8(logic [31:0] v);
        return (&v[31:7]) || !(|v[31:7]);
    endfunction

    function automatic logic [7:0] modrm_byte(logic [1:0] m, logic [2:0] r, logic [2:0] rm);
        return {m, r, rm};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/x86e_ifs.sv =====
// handshake channels of the alu instruction encoder: instruction in, code byte out
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface x86e_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [2:0]         alu_op;
    logic [1:0]         size_code;
    logic [2:0]         reg_code;
    logic [2:0]         rm_base_reg;
    logic               no_base;
    logic               has_index;
    logic [2:0]         index_reg;
    logic [1:0]         scale_log;
    logic signed [31:0] displacement;
    logic signed [31:0] immediate;

    modport source (
        output valid, kind, alu_op, size_code, reg_code, rm_base_reg, no_base,
               has_index, index_reg, scale_log, displacement, immediate,
        input  ready
    );
    modport sink (
        input  valid, kind, alu_op, size_code, reg_code, rm_base_reg, no_base,
               has_index, index_reg, scale_log, displacement, immediate,
        output ready
    );
endinterface

interface x86e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;
    logic       illegal;

    modport source (output valid, code_byte, last, illegal, input ready);
    modport sink   (input valid, code_byte, last, illegal, output ready);
endinterface

`default_nettype wire

// ===== rtl/x86e_front.sv =====
// front end: accepts an instruction and builds its full byte image and length
// depends on x86e_pkg and x86e_in_if
`timescale 1ns / 1ps
`default_nettype none

module x86e_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    x86e_in_if.sink            i_in,
    output x86e_pkg::t_desc    o_desc,
    output logic               o_valid,
    input  wire logic          i_ready
);

    logic            r_valid;
    x86e_pkg::t_desc r_desc;
    x86e_pkg::t_desc n_desc;

    logic       is_illegal;
    logic       has66;
    logic       has_modrm;
    logic       has_sib;
    logic       mem_form;
    logic       w_bit;
    logic       imm_fits;
    logic       disp_fits;
    logic [7:0] opcode;
    logic [7:0] modrm_b;
    logic [7:0] sib_b;
    logic [7:0] mem_modrm;
    logic [7:0] mem_sib;
    logic       mem_has_sib;
    logic [2:0] mem_disp_len;
    logic [1:0] mod_v;
    logic [2:0] r_field;
    logic [2:0] nsz;
    logic [2:0] disp_len;
    logic [2:0] imm_len;
    logic [7:0] grp_opcode;
    logic [2:0] grp_imm_len;
    logic [31:0] disp_u;
    logic [31:0] imm_u;
    logic [3:0][7:0] disp_bytes;
    logic [3:0][7:0] imm_bytes;
    logic [3:0] off_op;
    logic [3:0] off_modrm;
    logic [3:0] off_sib;
    logic [3:0] off_disp;
    logic [3:0] off_imm;
    logic [3:0] total;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_desc     = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_desc <= n_desc;
        end
    end

    // operand classification
    always_comb begin
        disp_u     = i_in.displacement;
        imm_u      = i_in.immediate;
        disp_bytes = disp_u;
        imm_bytes  = imm_u;
        is_illegal = (i_in.kind > x86e_pkg::KIND_MEM_IMM) || (i_in.size_code == x86e_pkg::SIZE_RSVD);
        has66      = (i_in.size_code == x86e_pkg::SIZE_WORD);
        w_bit      = (i_in.size_code != x86e_pkg::SIZE_BYTE);
        imm_fits   = x86e_pkg::fits8(imm_u);
        disp_fits  = x86e_pkg::fits8(disp_u);
        unique case (i_in.size_code)
            x86e_pkg::SIZE_BYTE: nsz = 3'd1;
            x86e_pkg::SIZE_WORD: nsz = 3'd2;
            default:             nsz = 3'd4;
        endcase
        if (i_in.size_code == x86e_pkg::SIZE_BYTE) begin
            grp_opcode  = x86e_pkg::OPC_GRP1_B;
            grp_imm_len = 3'd1;
        end else if (imm_fits) begin
            grp_opcode  = x86e_pkg::OPC_GRP1_IMM8;
            grp_imm_len = 3'd1;
        end else begin
            grp_opcode  = x86e_pkg::OPC_GRP1_V;
            grp_imm_len = nsz;
        end

        mem_form = (i_in.kind == x86e_pkg::KIND_REG_MEM) || (i_in.kind == x86e_pkg::KIND_MEM_REG)
                   || (i_in.kind == x86e_pkg::KIND_MEM_IMM);
        r_field  = (i_in.kind == x86e_pkg::KIND_MEM_IMM) ? i_in.alu_op : i_in.reg_code;

        // memory operand
        if (i_in.no_base) begin
            mod_v        = x86e_pkg::MOD_NODISP;
            mem_disp_len = 3'd4;
            mem_has_sib  = i_in.has_index;
            mem_sib      = x86e_pkg::modrm_byte(i_in.scale_log, i_in.index_reg, x86e_pkg::RM_DISP32);
            mem_modrm    = x86e_pkg::modrm_byte(mod_v, r_field,
                               i_in.has_index ? x86e_pkg::RM_SIB : x86e_pkg::RM_DISP32);
        end else begin
            if (disp_u == 32'd0 && i_in.rm_base_reg != x86e_pkg::REG_EBP) begin
                mod_v = x86e_pkg::MOD_NODISP;
            end else if (disp_fits) begin
                mod_v = x86e_pkg::MOD_DISP8;
            end else begin
                mod_v = x86e_pkg::MOD_DISP32;
            end
            unique case (mod_v)
                x86e_pkg::MOD_DISP8:  mem_disp_len = 3'd1;
                x86e_pkg::MOD_DISP32: mem_disp_len = 3'd4;
                default:              mem_disp_len = 3'd0;
            endcase
            if (i_in.has_index) begin
                mem_has_sib = 1'b1;
                mem_modrm   = x86e_pkg::modrm_byte(mod_v, r_field, x86e_pkg::RM_SIB);
                mem_sib     = x86e_pkg::modrm_byte(i_in.scale_log, i_in.index_reg,
                                                   i_in.rm_base_reg);
            end else if (i_in.rm_base_reg == x86e_pkg::REG_ESP) begin
                mem_has_sib = 1'b1;
                mem_modrm   = x86e_pkg::modrm_byte(mod_v, r_field, x86e_pkg::RM_SIB);
                mem_sib     = x86e_pkg::SIB_ESP_BASE;
            end else begin
                mem_has_sib = 1'b0;
                mem_modrm   = x86e_pkg::modrm_byte(mod_v, r_field, i_in.rm_base_reg);
                mem_sib     = x86e_pkg::SIB_ESP_BASE;
            end
        end

        // opcode and operand layout per form
        opcode    = 8'h00;
        has_modrm = 1'b1;
        imm_len   = 3'd0;
        modrm_b   = mem_modrm;
        unique case (i_in.kind)
            x86e_pkg::KIND_REG_REG: begin
                opcode  = {2'b00, i_in.alu_op, 1'b0, 1'b1, w_bit};
                modrm_b = x86e_pkg::modrm_byte(x86e_pkg::MOD_REG, i_in.reg_code, i_in.rm_base_reg);
            end
            x86e_pkg::KIND_REG_MEM: begin
                opcode = {2'b00, i_in.alu_op, 1'b0, 1'b1, w_bit};
            end
            x86e_pkg::KIND_MEM_REG: begin
                opcode = {2'b00, i_in.alu_op, 1'b0, 1'b0, w_bit};
            end
            x86e_pkg::KIND_REG_IMM: begin
                if (i_in.reg_code == x86e_pkg::REG_ACC) begin
                    opcode    = {2'b00, i_in.alu_op, 2'b10, w_bit};
                    has_modrm = 1'b0;
                    imm_len   = nsz;
                end else begin
                    opcode  = grp_opcode;
                    imm_len = grp_imm_len;
                    modrm_b = x86e_pkg::modrm_byte(x86e_pkg::MOD_REG, i_in.alu_op, i_in.reg_code);
                end
            end
            x86e_pkg::KIND_MEM_IMM: begin
                opcode  = grp_opcode;
                imm_len = grp_imm_len;
            end
            default: begin
                opcode = 8'h00;
            end
        endcase
        has_sib  = mem_form && mem_has_sib;
        sib_b    = mem_sib;
        disp_len = mem_form ? mem_disp_len : 3'd0;

        off_op    = {3'b000, has66};
        off_modrm = off_op + 4'd1;
        off_sib   = off_modrm + {3'b000, has_modrm};
        off_disp  = off_sib + {3'b000, has_sib};
        off_imm   = off_disp + {1'b0, disp_len};
        total     = off_imm + {1'b0, imm_len};

        // byte image
        for (int i = 0; i < x86e_pkg::MAX_BYTES; i++) begin
            if (has66 && 4'(i) == 4'd0) begin
                n_desc.bytes[i] = x86e_pkg::PFX_OPSIZE;
            end else if (4'(i) == off_op) begin
                n_desc.bytes[i] = opcode;
            end else if (has_modrm && 4'(i) == off_modrm) begin
                n_desc.bytes[i] = modrm_b;
            end else if (has_sib && 4'(i) == off_sib) begin
                n_desc.bytes[i] = sib_b;
            end else if (4'(i) >= off_disp && 4'(i) < off_imm) begin
                n_desc.bytes[i] = disp_bytes[2'(4'(i) - off_disp)];
            end else if (4'(i) >= off_imm && 4'(i) < total) begin
                n_desc.bytes[i] = imm_bytes[2'(4'(i) - off_imm)];
            end else begin
                n_desc.bytes[i] = 8'h00;
            end
        end
        n_desc.len     = total;
        n_desc.illegal = 1'b0;
        if (is_illegal) begin
            n_desc.bytes   = '0;
            n_desc.len     = 4'd1;
            n_desc.illegal = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/x86e_queue.sv =====
// small descriptor queue between the front end and the byte emitter
// depends on x86e_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module x86e_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire x86e_pkg::t_desc  i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output x86e_pkg::t_desc       o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    x86e_pkg::t_desc  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd];
    assign n_wr         = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd         = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    `X86E_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== rtl/x86e_back.sv =====
// byte emitter: walks the queue head one byte per cycle while the output is not stalled, into an output register
// depends on x86e_pkg, x86e_out_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module x86e_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire x86e_pkg::t_desc  i_desc,
    output logic                  o_pop,
    x86e_out_if.source            o_out
);

    logic [x86e_pkg::IDX_W-1:0] r_idx;
    logic [x86e_pkg::IDX_W-1:0] n_idx;
    logic                       r_out_valid;
    logic [7:0]                 r_byte;
    logic                       r_last;
    logic                       r_illegal;
    logic                       can_load;
    logic                       emit;
    logic                       is_end;

    assign can_load = !r_out_valid || o_out.ready;
    assign emit     = i_valid && can_load;
    assign is_end   = (r_idx == i_desc.len - 1'b1);
    assign o_pop    = emit && is_end;
    assign n_idx    = is_end ? '0 : r_idx + 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.code_byte = r_byte;
    assign o_out.last      = r_last;
    assign o_out.illegal   = r_illegal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx <= n_idx;
            end
            if (can_load) begin
                r_out_valid <= i_valid;
            end
        end
        if (emit) begin
            r_byte    <= i_desc.bytes[r_idx];
            r_last    <= is_end;
            r_illegal <= i_desc.illegal;
        end
    end

    `X86E_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, i_valid, r_idx < i_desc.len, "byte index past length")
    `X86E_ASSERT_IMPL(a_illegal_last, i_clk, i_rst_n, r_out_valid && r_illegal, r_last, "illegal not single")
    `X86E_ASSERT(a_pop_restart, i_clk, i_rst_n, o_pop |=> (r_idx == '0), "index not rewound after pop")

endmodule

`default_nettype wire

// ===== rtl/x86_alu_instruction_encoder.sv =====
// path: an instruction is registered in the front end, then held in the queue, then walked into the output register
// throughput: one code byte per cycle while the output is not stalled; an instruction has 1 to 11 code bytes
// the byte emitter walking the queue head sets that rate; the front end takes one per cycle while the queue has room
// reset: synchronous active-low i_rst_n empties the queue and output; no clearing pass
// top of the alu instruction encoder; depends on x86e_pkg, x86e_ifs, x86e_front, x86e_queue, x86e_back
`timescale 1ns / 1ps
`default_nettype none

module x86_alu_instruction_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    x86e_in_if.sink    i_in,
    x86e_out_if.source o_out
);

    x86e_pkg::t_desc front_desc;
    x86e_pkg::t_desc head_desc;
    logic            front_valid;
    logic            front_ready;
    logic            head_valid;
    logic            head_pop;

    x86e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_desc  (front_desc),
        .o_valid (front_valid),
        .i_ready (front_ready)
    );

    x86e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_desc),
        .o_pop_valid  (head_valid),
        .i_pop_ready  (head_pop),
        .o_pop_data   (head_desc)
    );

    x86e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_desc  (head_desc),
        .o_pop   (head_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/x86e_code_checker.sv =====
// checker for the alu instruction encoder: watches both channels, predicts the code bytes
// of every accepted instruction and compares each emitted byte; depends on x86e_pkg, x86e_ifs
`timescale 1ns / 1ps

module x86e_code_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    x86e_in_if        i_instr,
    x86e_out_if       i_code,
    output int        o_error_count,
    output int        o_pending
);
    import x86e_pkg::*;

    localparam logic [7:0] OPC_DIR_TO_REG = 8'h02;
    localparam logic [7:0] OPC_WIDE       = 8'h01;
    localparam logic [7:0] OPC_ACC_IMM_B  = 8'h04;
    localparam logic [7:0] OPC_ACC_IMM_V  = 8'h05;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic       illegal;
    } t_code_txn;

    t_code_txn  expected_code[$];
    logic [7:0] instr_bytes[$];
    int         errors = 0;

    function automatic bit is_simm8(logic [31:0] v);
        return $signed(v) >= -128 && $signed(v) <= 127;
    endfunction

    function automatic void push_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            instr_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_mem_operand(logic [2:0] r, logic [2:0] base, logic nobase,
                                             logic idx, logic [2:0] index, logic [1:0] scale,
                                             logic [31:0] disp);
        logic [1:0] mode;
        if (nobase) begin
            if (idx) begin
                instr_bytes.push_back({MOD_NODISP, r, RM_SIB});
                instr_bytes.push_back({scale, index, RM_DISP32});
            end else begin
                instr_bytes.push_back({MOD_NODISP, r, RM_DISP32});
            end
            push_le(disp, 4);
            return;
        end
        if (disp == 32'd0 && base != REG_EBP)
            mode = MOD_NODISP;
        else if (is_simm8(disp))
            mode = MOD_DISP8;
        else
            mode = MOD_DISP32;
        if (idx) begin
            instr_bytes.push_back({mode, r, RM_SIB});
            instr_bytes.push_back({scale, index, base});
        end else if (base == REG_ESP) begin
            instr_bytes.push_back({mode, r, RM_SIB});
            instr_bytes.push_back(SIB_ESP_BASE);
        end else begin
            instr_bytes.push_back({mode, r, base});
        end
        if (mode == MOD_DISP8)
            push_le(disp, 1);
        else if (mode == MOD_DISP32)
            push_le(disp, 4);
    endfunction

    function automatic void encode_instruction(logic [2:0] kind, logic [2:0] op,
                                               logic [1:0] size, logic [2:0] r,
                                               logic [2:0] base, logic nobase, logic idx,
                                               logic [2:0] index, logic [1:0] scale,
                                               logic [31:0] disp, logic [31:0] imm);
        int         nsz;
        int         isz;
        logic [7:0] opb;
        instr_bytes.delete();
        if (kind > KIND_MEM_IMM || size == SIZE_RSVD) begin
            expected_code.push_back(t_code_txn'{8'h00, 1'b1, 1'b1});
            return;
        end
        nsz = (size == SIZE_BYTE) ? 1 : (size == SIZE_WORD) ? 2 : 4;
        opb = {2'b00, op, 3'b000};
        if (size == SIZE_WORD)
            instr_bytes.push_back(PFX_OPSIZE);
        if (kind <= KIND_MEM_REG) begin
            instr_bytes.push_back(opb + ((kind == KIND_MEM_REG) ? 8'h00 : OPC_DIR_TO_REG)
                                      + ((size == SIZE_BYTE) ? 8'h00 : OPC_WIDE));
            if (kind == KIND_REG_REG)
                instr_bytes.push_back({MOD_REG, r, base});
            else
                push_mem_operand(r, base, nobase, idx, index, scale, disp);
        end else if (kind == KIND_REG_IMM && r == REG_ACC) begin
            instr_bytes.push_back(opb | ((size == SIZE_BYTE) ? OPC_ACC_IMM_B : OPC_ACC_IMM_V));
            push_le(imm, nsz);
        end else begin
            isz = nsz;
            if (size == SIZE_BYTE) begin
                instr_bytes.push_back(OPC_GRP1_B);
            end else if (is_simm8(imm)) begin
                instr_bytes.push_back(OPC_GRP1_IMM8);
                isz = 1;
            end else begin
                instr_bytes.push_back(OPC_GRP1_V);
            end
            if (kind == KIND_REG_IMM)
                instr_bytes.push_back({MOD_REG, op, r});
            else
                push_mem_operand(op, base, nobase, idx, index, scale, disp);
            push_le(imm, isz);
        end
        foreach (instr_bytes[i])
            expected_code.push_back(t_code_txn'{instr_bytes[i],
                                                i == instr_bytes.size() - 1, 1'b0});
    endfunction

    always @(posedge i_clk) begin : monitor
        t_code_txn want;
        if (!i_rst_n) begin
            expected_code.delete();
        end else begin
            if (i_instr.valid && i_instr.ready)
                encode_instruction(i_instr.kind, i_instr.alu_op, i_instr.size_code,
                                   i_instr.reg_code, i_instr.rm_base_reg, i_instr.no_base,
                                   i_instr.has_index, i_instr.index_reg, i_instr.scale_log,
                                   i_instr.displacement, i_instr.immediate);
            if (i_code.valid && i_code.ready) begin
                if (expected_code.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected code byte: expected none, actual %h/%b/%b",
                             $time, i_code.code_byte, i_code.last, i_code.illegal);
                end else begin
                    want = expected_code.pop_front();
                    if (i_code.code_byte !== want.code_byte || i_code.last !== want.last ||
                        i_code.illegal !== want.illegal) begin
                        errors++;
                        $display("%0t: code byte mismatch: expected %h/%b/%b, actual %h/%b/%b",
                                 $time, want.code_byte, want.last, want.illegal,
                                 i_code.code_byte, i_code.last, i_code.illegal);
                    end
                end
            end
        end
        o_error_count <= errors;
        o_pending     <= expected_code.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the alu instruction encoder testbench: clock, reset, instruction stimulus,
// output back-pressure and the verdict; depends on x86e_pkg, x86e_ifs, the encoder top and x86e_code_checker
`timescale 1ns / 1ps

module testbench;
    import x86e_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 420;
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int DRAIN_LIMIT  = 200000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  alu_op;
        logic [1:0]  size_code;
        logic [2:0]  reg_code;
        logic [2:0]  rm_base_reg;
        logic        no_base;
        logic        has_index;
        logic [2:0]  index_reg;
        logic [1:0]  scale_log;
        logic [31:0] displacement;
        logic [31:0] immediate;
    } t_alu_instr;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_pct;
    int   stall_pct;
    logic hold_request;
    int   hold_left;
    int   error_count;
    int   pending_count;

    x86e_in_if  instr_ch ();
    x86e_out_if code_ch ();

    x86_alu_instruction_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (code_ch)
    );

    x86e_code_checker code_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_instr       (instr_ch),
        .i_code        (code_ch),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // output side: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            code_ch.ready <= 1'b0;
        end else begin
            code_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_alu_instr make_instr(logic [2:0] kind, logic [2:0] op,
                                              logic [1:0] size, logic [2:0] r,
                                              logic [2:0] base, logic nobase, logic idx,
                                              logic [2:0] index, logic [1:0] scale,
                                              logic [31:0] disp, logic [31:0] imm);
        return t_alu_instr'{kind, op, size, r, base, nobase, idx, index, scale, disp, imm};
    endfunction

    // operand values biased toward zero, the signed byte and word ranges, byte and dword edges, and any value
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0: return 32'd0;
            1: return {{24{v[7]}}, v[7:0]};
            2: begin
                case ($urandom_range(7))
                    0: return 32'd127;
                    1: return 32'd128;
                    2: return 32'hffff_ff80;
                    3: return 32'hffff_ff7f;
                    4: return 32'h7fff_ffff;
                    5: return 32'h8000_0000;
                    6: return 32'hffff_ffff;
                    default: return 32'd255;
                endcase
            end
            3: return {{16{v[15]}}, v[15:0]};
            default: return v;
        endcase
    endfunction

    function automatic t_alu_instr random_instr();
        t_alu_instr t;
        t.kind         = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 5))
                                                  : 3'($urandom_range(KIND_MEM_IMM));
        t.size_code    = ($urandom_range(99) < 4) ? SIZE_RSVD : 2'($urandom_range(SIZE_DWORD));
        t.alu_op       = 3'($urandom);
        t.reg_code     = 3'($urandom);
        t.rm_base_reg  = 3'($urandom);
        t.no_base      = ($urandom_range(99) < 20);
        t.has_index    = 1'($urandom);
        t.index_reg    = 3'($urandom);
        t.scale_log    = 2'($urandom);
        t.displacement = pick_value();
        t.immediate    = pick_value();
        return t;
    endfunction

    task automatic send_instr(t_alu_instr t);
        while ($urandom_range(99) < idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_ch.kind         <= t.kind;
        instr_ch.alu_op       <= t.alu_op;
        instr_ch.size_code    <= t.size_code;
        instr_ch.reg_code     <= t.reg_code;
        instr_ch.rm_base_reg  <= t.rm_base_reg;
        instr_ch.no_base      <= t.no_base;
        instr_ch.has_index    <= t.has_index;
        instr_ch.index_reg    <= t.index_reg;
        instr_ch.scale_log    <= t.scale_log;
        instr_ch.displacement <= t.displacement;
        instr_ch.immediate    <= t.immediate;
        instr_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!instr_ch.ready);
    endtask

    initial begin
        int waited;
        instr_ch.valid        = 1'b0;
        instr_ch.kind         = KIND_REG_REG;
        instr_ch.alu_op       = 3'd0;
        instr_ch.size_code    = SIZE_BYTE;
        instr_ch.reg_code     = 3'd0;
        instr_ch.rm_base_reg  = 3'd0;
        instr_ch.no_base      = 1'b0;
        instr_ch.has_index    = 1'b0;
        instr_ch.index_reg    = 3'd0;
        instr_ch.scale_log    = 2'd0;
        instr_ch.displacement = 32'd0;
        instr_ch.immediate    = 32'd0;
        code_ch.ready         = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        hold_request          = 1'b0;
        hold_left             = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every form, size and operation, addressing corner cases
        send_instr(make_instr(KIND_REG_REG, 3'd0, SIZE_BYTE, 3'd7, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'hffff_ffff, 32'hffff_ffff));
        send_instr(make_instr(KIND_REG_REG, 3'd7, SIZE_DWORD, 3'd0, 3'd7, 1, 1, 3'd7, 2'd3,
                              32'd0, 32'd0));
        send_instr(make_instr(KIND_REG_MEM, 3'd1, SIZE_WORD, 3'd2, REG_ESP, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd0));
        send_instr(make_instr(KIND_MEM_REG, 3'd2, SIZE_DWORD, 3'd3, REG_EBP, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd0));
        send_instr(make_instr(KIND_REG_MEM, 3'd3, SIZE_DWORD, 3'd5, 3'd1, 1, 0, 3'd0, 2'd0,
                              32'h8000_0000, 32'd0));
        send_instr(make_instr(KIND_REG_MEM, 3'd4, SIZE_DWORD, 3'd6, 3'd3, 0, 1, REG_ESP, 2'd3,
                              32'd127, 32'd0));
        send_instr(make_instr(KIND_MEM_REG, 3'd5, SIZE_BYTE, 3'd1, 3'd6, 1, 1, 3'd2, 2'd1,
                              32'hffff_ffff, 32'd0));
        send_instr(make_instr(KIND_REG_MEM, 3'd6, SIZE_WORD, 3'd4, REG_EBP, 0, 0, 3'd0, 2'd0,
                              32'hffff_ff7f, 32'd0));
        send_instr(make_instr(KIND_MEM_REG, 3'd7, SIZE_BYTE, 3'd7, REG_ESP, 0, 0, 3'd0, 2'd0,
                              32'd4, 32'd0));
        send_instr(make_instr(KIND_MEM_REG, 3'd0, SIZE_DWORD, 3'd0, REG_EBP, 0, 1, 3'd1, 2'd2,
                              32'h7fff_ffff, 32'd0));
        send_instr(make_instr(KIND_REG_IMM, 3'd6, SIZE_BYTE, REG_ACC, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd127));
        send_instr(make_instr(KIND_REG_IMM, 3'd7, SIZE_WORD, REG_ACC, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'hffff_8000));
        send_instr(make_instr(KIND_REG_IMM, 3'd0, SIZE_DWORD, REG_ACC, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'h7fff_ffff));
        send_instr(make_instr(KIND_REG_IMM, 3'd1, SIZE_BYTE, 3'd3, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'hffff_ff80));
        send_instr(make_instr(KIND_REG_IMM, 3'd2, SIZE_WORD, 3'd5, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd127));
        send_instr(make_instr(KIND_REG_IMM, 3'd3, SIZE_WORD, 3'd6, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd128));
        send_instr(make_instr(KIND_REG_IMM, 3'd4, SIZE_DWORD, 3'd1, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'hffff_ff7f));
        send_instr(make_instr(KIND_MEM_IMM, 3'd5, SIZE_DWORD, 3'd0, REG_ESP, 0, 1, 3'd5, 2'd1,
                              32'd128, 32'h8000_0000));
        send_instr(make_instr(KIND_MEM_IMM, 3'd6, SIZE_WORD, 3'd0, 3'd2, 0, 0, 3'd0, 2'd0,
                              32'hffff_ff80, 32'hffff_ffff));
        send_instr(make_instr(KIND_MEM_IMM, 3'd7, SIZE_BYTE, 3'd0, 3'd7, 1, 1, 3'd6, 2'd0,
                              32'h1234_5678, 32'd255));
        send_instr(make_instr(3'd5, 3'd0, SIZE_DWORD, 3'd0, 3'd0, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd0));
        send_instr(make_instr(3'd7, 3'd7, SIZE_BYTE, 3'd7, 3'd7, 1, 1, 3'd7, 2'd3,
                              32'hffff_ffff, 32'hffff_ffff));
        send_instr(make_instr(KIND_REG_REG, 3'd1, SIZE_RSVD, 3'd2, 3'd3, 0, 0, 3'd0, 2'd0,
                              32'd0, 32'd0));
        send_instr(make_instr(KIND_MEM_IMM, 3'd2, SIZE_RSVD, 3'd0, 3'd1, 0, 0, 3'd0, 2'd0,
                              32'd8, 32'd8));

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            // long output hold-off while instructions keep coming
            if (phase == 0)
                hold_request = 1'b1;
            repeat (RANDOM_ITEMS / PHASES) send_instr(random_instr());
        end
        instr_ch.valid <= 1'b0;

        @(posedge i_clk);
        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_count != 0)
            $display("%0t: %0d code bytes never arrived", $time, pending_count);
        if (error_count == 0 && pending_count == 0)
            $display("** x86_alu_instruction_encoder: PASSED **");
        else
            $display("** x86_alu_instruction_encoder: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** x86_alu_instruction_encoder: FAILED **");
        $finish;
    end

endmodule
